### design/trailing_moving_average_defines.svh
// Assertion macros shared by the RTL. Every assertion is clocked on clock.
`ifndef TRAILING_MOVING_AVERAGE_DEFINES_SVH
`define TRAILING_MOVING_AVERAGE_DEFINES_SVH
`ifndef SYNTHESIS
`define TMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TMA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TMA_ASSERT(label, prop, msg)
`define TMA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### design/tma_pkg.sv
`default_nettype none

package tma_pkg;

   localparam int SAMPLE_W           = 32;
   localparam int WINDOW_W           = 9;
   localparam int WINDOW_MAX_DEFAULT = 256;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_DIVIDE = 3'b100
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

### design/tma_ram.sv
`default_nettype none

module tma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/tma_divider.sv
`default_nettype none

// Signed by unsigned restoring divider, one quotient bit per cycle.
// The quotient is truncated toward zero and stays valid while not busy.
module tma_divider #(
   parameter int DIVIDEND_W = 40,
   parameter int DIVISOR_W  = 9,
   parameter int QUOT_W     = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]         divisor,
   output      logic signed [QUOT_W-1:0]     quotient,
   output      tma_pkg::div_status_type      status
);

   import tma_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [DIVIDEND_W-1:0] magnitude;
   logic [DIVIDEND_W-1:0] signed_quo;

   always_comb begin
      magnitude = dividend[DIVIDEND_W-1] ? (~dividend + DIVIDEND_W'(1)) : dividend;
      trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits      = (trial >= {1'b0, den_ff});
      diff      = trial - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = magnitude;
         den_in  = divisor;
         neg_in  = dividend[DIVIDEND_W-1];
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits after the subtract.
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign signed_quo  = neg_ff ? (~quo_ff + DIVIDEND_W'(1)) : quo_ff;
   assign quotient    = signed_quo[QUOT_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

### design/trailing_moving_average.sv
`default_nettype none
// Channel  | Ports                                       | Direction
// req      | req_valid, req_ready, req_sample, req_first | in, valid/ready
// rsp      | rsp_valid, rsp_ready, rsp_average           | out, valid/ready
// csr      | csr_write_enable, csr_write_data            | in, write only
//
// A transaction runs in order: on accept the ring is read, ST_UPDATE updates the
// running sum and starts the divider, the divider works through each bit of the
// SUM_W-bit sum, and ST_DIVIDE then loads the output register.
// Reset is synchronous; ring entries are only read after being written in the
// current sequence, so no clearing pass is needed.
// A result may wait in the output register while the next transaction runs; the
// next quotient is then held, with req_ready low, until that register is free.

`include "trailing_moving_average_defines.svh"

module trailing_moving_average #(
   parameter int WINDOW_MAX = tma_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic signed [tma_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_first,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [tma_pkg::SAMPLE_W-1:0] rsp_average,
   input  wire logic                                csr_write_enable,
   input  wire logic [tma_pkg::WINDOW_W-1:0]        csr_write_data
);

   import tma_pkg::*;

   localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = SAMPLE_W + ADDR_W;

   state_type             state_ff, state_in;
   logic [WINDOW_W-1:0]   window_length_ff;
   logic [CNT_W-1:0]      active_window_ff, active_window_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic                  evict_ff, evict_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_average_ff, rsp_average_in;

   logic                  accept;
   logic [CNT_W-1:0]      window_clamped;
   logic [CNT_W-1:0]      start_count;
   logic [CNT_W-1:0]      start_window;
   logic [ADDR_W-1:0]     start_pos;
   logic [CNT_W-1:0]      pos_plus;
   logic signed [SUM_W-1:0] evict_value;
   logic signed [SUM_W-1:0] sum_update;
   logic [CNT_W-1:0]      count_update;
   logic [SAMPLE_W-1:0]   ram_rd_data;
   logic                  ram_wr_en;
   logic                  div_start;
   logic signed [SAMPLE_W-1:0] div_quotient;
   div_status_type        div_status;
   logic                  out_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (window_length_ff == '0) begin
         window_clamped = CNT_W'(1);
      end else if (32'(window_length_ff) > 32'(WINDOW_MAX)) begin
         window_clamped = CNT_W'(WINDOW_MAX);
      end else begin
         window_clamped = CNT_W'(window_length_ff);
      end
   end

   always_comb begin
      start_count  = req_first ? '0 : count_ff;
      // The window is latched only when a sequence begins.
      start_window = (start_count == '0) ? window_clamped : active_window_ff;
      start_pos    = (start_count == '0) ? '0 : pos_ff;
      if (CNT_W'(start_pos) >= start_window) begin
         start_pos = '0;
      end

      evict_value  = evict_ff ? SUM_W'(signed'(ram_rd_data)) : '0;
      sum_update   = sum_ff - evict_value + SUM_W'(signed'(sample_ff));
      pos_plus     = CNT_W'(pos_ff) + CNT_W'(1);
      count_update = (count_ff < active_window_ff) ? count_ff + CNT_W'(1) : count_ff;

      state_in         = state_ff;
      active_window_in = active_window_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      sum_in           = sum_ff;
      sample_in        = sample_ff;
      evict_in         = evict_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_average_in   = rsp_average_ff;
      ram_wr_en        = 1'b0;
      div_start        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               active_window_in = start_window;
               count_in         = start_count;
               pos_in           = start_pos;
               sum_in           = (start_count == '0) ? '0 : sum_ff;
               sample_in        = req_sample;
               evict_in         = (start_count >= start_window);
               state_in         = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ram_wr_en = 1'b1;
            sum_in    = sum_update;
            count_in  = count_update;
            pos_in    = (pos_plus >= active_window_ff) ? '0 : ADDR_W'(pos_plus);
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_status.busy && out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = div_quotient;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_length_ff <= WINDOW_RESET;
         active_window_ff <= CNT_W'(1);
         count_ff         <= '0;
         pos_ff           <= '0;
         sum_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         active_window_ff <= active_window_in;
         count_ff         <= count_in;
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_write_enable) begin
            window_length_ff <= csr_write_data;
         end
      end
      sample_ff      <= sample_in;
      evict_ff       <= evict_in;
      rsp_average_ff <= rsp_average_in;
   end

   tma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (start_pos),
      .rd_data (ram_rd_data)
   );

   tma_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W),
      .QUOT_W     (SAMPLE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_update),
      .divisor  (count_update),
      .quotient (div_quotient),
      .status   (div_status)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   `TMA_ASSERT(a_count_in_window, count_ff <= active_window_ff, "count exceeds window")
   `TMA_ASSERT(a_pos_in_window, CNT_W'(pos_ff) < active_window_ff, "ring position out of window")
   `TMA_ASSERT(a_result_from_divide, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DIVIDE,
      "result loaded outside divide")
   `TMA_ASSERT(a_done_in_divide, div_status.done |-> state_ff == ST_DIVIDE,
      "divider finished outside divide")

endmodule

`default_nettype wire
